// File: rtl/core/pcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_pkg
// Shared types and constants for the patch coordinate mapper.
// ----------------------------------------------------------------------------
package pcm_pkg;

  localparam int COORD_BITS_DEF = 16;

  localparam logic DIR_VIEW_TO_ATLAS = 1'b0;
  localparam logic DIR_ATLAS_TO_VIEW = 1'b1;

  typedef enum logic [2:0] {
    ORIENT_NONE    = 3'd0,
    ORIENT_SWAP    = 3'd1,
    ORIENT_ROT90   = 3'd2,
    ORIENT_ROT180  = 3'd3,
    ORIENT_ROT270  = 3'd4,
    ORIENT_MIRROR  = 3'd5,
    ORIENT_MROT90  = 3'd6,
    ORIENT_MROT180 = 3'd7
  } orient_t;

  // per-item axis routing: swap picks the crossed position axis,
  // neg_x / neg_y reflect that output inside the patch
  typedef struct packed {
    logic swap;
    logic neg_x;
    logic neg_y;
  } axis_ctl_t;

endpackage

// File: rtl/core/patch_coordinate_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// patch_coordinate_mapper
// Maps a pixel position between a view and a packed atlas for one patch.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) carries the direction, the position,
//   the patch size and both patch corners, and the orientation code. Output
//   channel (out_valid / out_ready) carries the mapped position as signed
//   COORD_BITS+3 bit values. One result per input transfer, in order.
//   out_valid rises once the input transfer has passed the input register,
//   then the result register with the adder logic in between.
//   Throughput: one item per clock while out_ready stays high; the result
//   register frees as it is taken, so a new item enters in the same cycle a
//   result leaves. When the receiver stalls, the result holds and the input
//   register keeps one more item; in_ready drops only while both are full.
//   Reset (rst, synchronous) empties both registers. No other state: inputs
//   need no setup, and positions outside the patch are mapped as-is.
// ----------------------------------------------------------------------------
module patch_coordinate_mapper
  import pcm_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         req_type,
  input  logic [COORD_BITS-1:0]        pos_x,
  input  logic [COORD_BITS-1:0]        pos_y,
  input  logic [COORD_BITS:0]          patch_w,
  input  logic [COORD_BITS:0]          patch_h,
  input  logic [COORD_BITS-1:0]        view_corner_x,
  input  logic [COORD_BITS-1:0]        view_corner_y,
  input  logic [COORD_BITS-1:0]        atlas_corner_x,
  input  logic [COORD_BITS-1:0]        atlas_corner_y,
  input  logic [2:0]                   orientation,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS+2:0] mapped_x,
  output logic signed [COORD_BITS+2:0] mapped_y
);

  localparam int OUT_W = COORD_BITS + 3;

  // input register
  logic                  s1_valid;
  logic                  r_req_type;
  logic [COORD_BITS-1:0] r_pos_x;
  logic [COORD_BITS-1:0] r_pos_y;
  logic [COORD_BITS:0]   r_patch_w;
  logic [COORD_BITS:0]   r_patch_h;
  logic [COORD_BITS-1:0] r_view_x;
  logic [COORD_BITS-1:0] r_view_y;
  logic [COORD_BITS-1:0] r_atlas_x;
  logic [COORD_BITS-1:0] r_atlas_y;
  logic [2:0]            r_orientation;

  logic                    out_take;
  axis_ctl_t               ctl;
  logic [COORD_BITS-1:0]   src_x, src_y, dst_x, dst_y;
  logic [COORD_BITS:0]     size_x, size_y;
  logic signed [OUT_W-1:0] mapped_x_next;
  logic signed [OUT_W-1:0] mapped_y_next;

  function automatic axis_ctl_t axis_ctl(input logic dir, input logic [2:0] code);
    axis_ctl_t c;
    c = '0;
    case (orient_t'(code))
      ORIENT_NONE:    c = 3'b000;
      ORIENT_SWAP:    c = 3'b100;
      ORIENT_ROT90:   c = (dir == DIR_VIEW_TO_ATLAS) ? 3'b110 : 3'b101;
      ORIENT_ROT180:  c = 3'b011;
      ORIENT_ROT270:  c = (dir == DIR_VIEW_TO_ATLAS) ? 3'b101 : 3'b110;
      ORIENT_MIRROR:  c = 3'b010;
      ORIENT_MROT90:  c = 3'b111;
      ORIENT_MROT180: c = 3'b001;
      default:        c = 3'b000;
    endcase
    return c;
  endfunction

  // neg: -p + ca + cb + sz - 1, else p - ca + cb
  function automatic logic signed [OUT_W-1:0] map_axis(
    input logic [COORD_BITS-1:0] p,
    input logic [COORD_BITS-1:0] ca,
    input logic [COORD_BITS-1:0] cb,
    input logic [COORD_BITS:0]   sz,
    input logic                  neg
  );
    logic signed [OUT_W-1:0] pe, cae, cbe, sze, one;
    pe  = signed'({{(OUT_W-COORD_BITS){1'b0}}, p});
    cae = signed'({{(OUT_W-COORD_BITS){1'b0}}, ca});
    cbe = signed'({{(OUT_W-COORD_BITS){1'b0}}, cb});
    sze = signed'({{(OUT_W-COORD_BITS-1){1'b0}}, sz});
    one = signed'({{(OUT_W-1){1'b0}}, 1'b1});
    if (neg) begin
      return cae - pe + cbe + sze - one;
    end
    return pe - cae + cbe;
  endfunction

  assign out_take = !out_valid || out_ready;
  assign in_ready = !s1_valid || out_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      r_req_type    <= req_type;
      r_pos_x       <= pos_x;
      r_pos_y       <= pos_y;
      r_patch_w     <= patch_w;
      r_patch_h     <= patch_h;
      r_view_x      <= view_corner_x;
      r_view_y      <= view_corner_y;
      r_atlas_x     <= atlas_corner_x;
      r_atlas_y     <= atlas_corner_y;
      r_orientation <= orientation;
    end
  end

  always_comb begin
    ctl = axis_ctl(r_req_type, r_orientation);
    // corners of the space the position lives in, and of the target space
    if (r_req_type == DIR_VIEW_TO_ATLAS) begin
      src_x  = r_view_x;
      src_y  = r_view_y;
      dst_x  = r_atlas_x;
      dst_y  = r_atlas_y;
      // extent of the source axis feeding each output
      size_x = ctl.swap ? r_patch_h : r_patch_w;
      size_y = ctl.swap ? r_patch_w : r_patch_h;
    end else begin
      src_x  = r_atlas_x;
      src_y  = r_atlas_y;
      dst_x  = r_view_x;
      dst_y  = r_view_y;
      size_x = r_patch_w;
      size_y = r_patch_h;
    end
    if (ctl.swap) begin
      mapped_x_next = map_axis(r_pos_y, src_y, dst_x, size_x, ctl.neg_x);
      mapped_y_next = map_axis(r_pos_x, src_x, dst_y, size_y, ctl.neg_y);
    end else begin
      mapped_x_next = map_axis(r_pos_x, src_x, dst_x, size_x, ctl.neg_x);
      mapped_y_next = map_axis(r_pos_y, src_y, dst_y, size_y, ctl.neg_y);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && out_take) begin
      mapped_x <= mapped_x_next;
      mapped_y <= mapped_y_next;
    end
  end

endmodule

// File: rtl/core/pcm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_checker
// Port-level checks for the patch coordinate mapper, bound to the top level.
// ----------------------------------------------------------------------------
module pcm_checker
  import pcm_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [COORD_BITS+2:0] mapped_x,
  input logic signed [COORD_BITS+2:0] mapped_y
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mapped_x) && $stable(mapped_y))
    else $error("result changed while stalled");

  // the input side only backs up behind a full result register
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("in_ready low with empty output");

  // draining the input register and then the result register with no new transfer leaves the block empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (!(in_valid && in_ready) && out_ready) ##1 (!(in_valid && in_ready) && out_ready)
    |=> !out_valid)
    else $error("result appeared without a matching input transfer");

endmodule

bind patch_coordinate_mapper pcm_checker #(.COORD_BITS(COORD_BITS)) u_pcm_checker (.*);
